// ===== design/usig_pkg.sv =====
// Package for the UV sphere index generator.
// Holds field widths, register codes, phase codes and the shared structs.
// No dependencies.
package usig_pkg;

   localparam int VTX_W = 16;
   localparam int CFG_W = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LAT_DIVISIONS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_DIVISIONS = 2'd1;

   localparam logic [CFG_W-1:0] LAT_RESET = 9'd12;
   localparam logic [CFG_W-1:0] LONG_RESET = 9'd24;
   localparam logic [CFG_W-1:0] LAT_MIN = 9'd2;
   localparam logic [CFG_W-1:0] LONG_MIN = 9'd3;

   localparam logic [1:0] PH_BAND = 2'd0;
   localparam logic [1:0] PH_BAND_WRAP = 2'd1;
   localparam logic [1:0] PH_CAP = 2'd2;
   localparam logic [1:0] PH_POLE_WRAP = 2'd3;

   typedef struct packed {
      logic [CFG_W-1:0] lat_m2;
      logic [CFG_W-1:0] lon;
      logic [CFG_W-1:0] lon_m1;
      logic             lat_is2;
      logic [VTX_W-1:0] north;
      logic [VTX_W-1:0] south;
      logic [VTX_W-1:0] last_row;
   } mesh_cfg_type;

   typedef struct packed {
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
      logic [VTX_W-1:0] vertex_c;
      logic             mesh_done;
   } triangle_type;

endpackage

// ===== design/usig_cfg.sv =====
// Configuration registers and the mesh constants derived from them.
// Depends on usig_pkg.
module usig_cfg import usig_pkg::*; #(
   parameter int MAX_DIVISIONS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output mesh_cfg_type         cfg,
   output logic                 pending
);

   localparam logic [CFG_W-1:0] MAX_DIV = CFG_W'(MAX_DIVISIONS);

   logic [CFG_W-1:0]   lat_raw_ff;
   logic [CFG_W-1:0]   lon_raw_ff;
   logic               pending_ff;
   mesh_cfg_type       cfg_ff;
   mesh_cfg_type       cfg_in;
   logic [CFG_W-1:0]   lat_sat;
   logic [CFG_W-1:0]   lon_sat;
   logic [2*CFG_W-1:0] last_row_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_raw_ff <= LAT_RESET;
         lon_raw_ff <= LONG_RESET;
         pending_ff <= 1'b1;
      end else begin
         pending_ff <= csr_write_en;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_LAT_DIVISIONS:  lat_raw_ff <= csr_data;
               CSR_LONG_DIVISIONS: lon_raw_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      lat_sat = (lat_raw_ff < LAT_MIN) ? LAT_MIN :
                (lat_raw_ff > MAX_DIV) ? MAX_DIV : lat_raw_ff;
      lon_sat = (lon_raw_ff < LONG_MIN) ? LONG_MIN :
                (lon_raw_ff > MAX_DIV) ? MAX_DIV : lon_raw_ff;
      last_row_prod   = (lat_sat - LAT_MIN) * lon_sat;
      cfg_in.lat_m2   = lat_sat - LAT_MIN;
      cfg_in.lon      = lon_sat;
      cfg_in.lon_m1   = lon_sat - CFG_W'(1);
      cfg_in.lat_is2  = (lat_sat == LAT_MIN);
      cfg_in.last_row = VTX_W'(last_row_prod);
      cfg_in.north    = VTX_W'(last_row_prod) + VTX_W'(lon_sat);
      cfg_in.south    = VTX_W'(last_row_prod) + VTX_W'(lon_sat) + VTX_W'(1);
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;
   assign pending = pending_ff;

endmodule

// ===== design/usig_walk.sv =====
// Walk state of the mesh and the triangle that the current step emits.
// Depends on usig_pkg.
module usig_walk import usig_pkg::*; #(
   parameter int MAX_DIVISIONS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  logic         advance,
   input  logic         restart,
   input  mesh_cfg_type cfg,
   output triangle_type tri_out
);

   localparam int CW = $clog2(MAX_DIVISIONS);

   logic [1:0]       phase_ff, phase_in, phase_cur;
   logic [CW-1:0]    row_ff, row_in, row_cur;
   logic [CW-1:0]    col_ff, col_in, col_cur;
   logic             half_ff, half_in, half_cur;
   logic [VTX_W-1:0] base_ff, base_in, base_cur;
   logic [VTX_W-1:0] nb;
   logic [VTX_W-1:0] colv;
   logic [VTX_W-1:0] lonv;
   logic [CW:0]      col_next;
   logic [CW:0]      row_next;
   logic             col_last;
   logic             row_last;
   triangle_type     tri_c;

   always_comb begin
      if (restart) begin
         phase_cur = PH_BAND;
         row_cur   = '0;
         col_cur   = '0;
         half_cur  = 1'b0;
         base_cur  = '0;
      end else begin
         phase_cur = phase_ff;
         row_cur   = row_ff;
         col_cur   = col_ff;
         half_cur  = half_ff;
         base_cur  = base_ff;
      end
      if (cfg.lat_is2 && (phase_cur == PH_BAND || phase_cur == PH_BAND_WRAP)) begin
         phase_cur = PH_CAP;
      end

      lonv     = VTX_W'(cfg.lon);
      nb       = base_cur + lonv;
      colv     = VTX_W'(col_cur);
      col_next = (CW+1)'(col_cur) + (CW+1)'(1);
      row_next = (CW+1)'(row_cur) + (CW+1)'(1);
      col_last = (CFG_W+1)'(col_next) >= (CFG_W+1)'(cfg.lon_m1);
      row_last = (CFG_W+1)'(row_next) >= (CFG_W+1)'(cfg.lat_m2);

      phase_in = phase_cur;
      row_in   = row_cur;
      col_in   = col_cur;
      half_in  = ~half_cur;
      base_in  = base_cur;
      tri_c.mesh_done = 1'b0;

      unique case (phase_cur)
         PH_BAND: begin
            if (!half_cur) begin
               tri_c.vertex_a = nb + colv + VTX_W'(1);
               tri_c.vertex_b = nb + colv;
               tri_c.vertex_c = base_cur + colv + VTX_W'(1);
            end else begin
               tri_c.vertex_a = base_cur + colv + VTX_W'(1);
               tri_c.vertex_b = nb + colv;
               tri_c.vertex_c = base_cur + colv;
               col_in = CW'(col_next);
               if (col_last) begin
                  col_in   = '0;
                  phase_in = PH_BAND_WRAP;
               end
            end
         end
         PH_BAND_WRAP: begin
            if (!half_cur) begin
               tri_c.vertex_a = nb;
               tri_c.vertex_b = nb + lonv - VTX_W'(1);
               tri_c.vertex_c = base_cur;
            end else begin
               tri_c.vertex_a = base_cur;
               tri_c.vertex_b = nb + lonv - VTX_W'(1);
               tri_c.vertex_c = base_cur + lonv - VTX_W'(1);
               row_in   = CW'(row_next);
               base_in  = nb;
               phase_in = row_last ? PH_CAP : PH_BAND;
            end
         end
         PH_CAP: begin
            if (!half_cur) begin
               tri_c.vertex_a = colv + VTX_W'(1);
               tri_c.vertex_b = colv;
               tri_c.vertex_c = cfg.north;
            end else begin
               tri_c.vertex_a = cfg.south;
               tri_c.vertex_b = cfg.last_row + colv;
               tri_c.vertex_c = cfg.last_row + colv + VTX_W'(1);
               col_in = CW'(col_next);
               if (col_last) begin
                  col_in   = '0;
                  phase_in = PH_POLE_WRAP;
               end
            end
         end
         default: begin
            if (!half_cur) begin
               tri_c.vertex_a = '0;
               tri_c.vertex_b = lonv - VTX_W'(1);
               tri_c.vertex_c = cfg.north;
            end else begin
               tri_c.vertex_a  = cfg.south;
               tri_c.vertex_b  = cfg.last_row + lonv - VTX_W'(1);
               tri_c.vertex_c  = cfg.last_row;
               tri_c.mesh_done = 1'b1;
               phase_in = PH_BAND;
               row_in   = '0;
               col_in   = '0;
               half_in  = 1'b0;
               base_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff <= PH_BAND;
         row_ff   <= '0;
         col_ff   <= '0;
         half_ff  <= 1'b0;
         base_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         half_ff  <= half_in;
         base_ff  <= base_in;
      end
   end

   assign tri_out = tri_c;

endmodule

// ===== design/uv_sphere_index_generator_top.sv =====
// Top level of the UV sphere index generator: request side, walk, result register.
// Depends on usig_pkg, usig_cfg and usig_walk.
//
//   Channel  Ports                                   Direction  Word
//   req      req_valid, req_stall, req_restart       in         one step request
//   rsp      rsp_valid, rsp_stall, rsp_vertex_*,     out        one triangle
//            rsp_mesh_done
//   csr      csr_write_en, csr_index, csr_data       in         register write
//
// One triangle per cycle while req_stall is low; a request enters the walk logic and its
// triangle is in the result register in the next cycle.
// The cycle after reset and the cycle after each register write stall requests while the
// derived mesh constants (pole indices, last ring row) are recomputed through one multiplier.
// A write to either setting register also restarts the mesh.
// A stalled result holds the request side only while the result register is full.
module uv_sphere_index_generator_top import usig_pkg::*; #(
   parameter int MAX_DIVISIONS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VTX_W-1:0]     rsp_vertex_a,
   output logic [VTX_W-1:0]     rsp_vertex_b,
   output logic [VTX_W-1:0]     rsp_vertex_c,
   output logic                 rsp_mesh_done,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   mesh_cfg_type cfg;
   logic         cfg_pending;
   logic         cfg_clear;
   logic         req_accept;
   triangle_type tri_next;
   triangle_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   usig_cfg #(
      .MAX_DIVISIONS(MAX_DIVISIONS)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg),
      .pending      (cfg_pending)
   );

   assign cfg_clear = csr_write_en &&
                      (csr_index == CSR_LAT_DIVISIONS || csr_index == CSR_LONG_DIVISIONS);

   usig_walk #(
      .MAX_DIVISIONS(MAX_DIVISIONS)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .clear   (cfg_clear),
      .advance (req_accept),
      .restart (req_restart),
      .cfg     (cfg),
      .tri_out (tri_next)
   );

   assign req_stall  = cfg_pending || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= tri_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vertex_a  = rsp_ff.vertex_a;
   assign rsp_vertex_b  = rsp_ff.vertex_b;
   assign rsp_vertex_c  = rsp_ff.vertex_c;
   assign rsp_mesh_done = rsp_ff.mesh_done;

`ifndef SYNTHESIS
   a_cfg_write_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> req_stall)
      else $error("request side open in the cycle after a register write");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no result word");

   a_reset_exit_stalls: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request side open before mesh constants are ready");
`endif

endmodule

// ===== tb/sv/tb_uv_sphere_index_generator_top.sv =====
// Self-checking testbench for uv_sphere_index_generator_top: directed rows, then random
// phases of register settings and step requests, checked against an in-bench predictor.
// Depends on usig_pkg and the uv_sphere_index_generator_top RTL.
`timescale 1ns / 1ps

module tb_uv_sphere_index_generator_top;
   import usig_pkg::*;

   localparam int MAX_DIVISIONS = 256;
   localparam int RANDOM_ITEMS = 1500;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic                   restart;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CFG_W-1:0]       data;
      bit                     typed;
      triangle_type           tri_want;
   } stim_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VTX_W-1:0]     rsp_vertex_a;
   logic [VTX_W-1:0]     rsp_vertex_b;
   logic [VTX_W-1:0]     rsp_vertex_c;
   logic                 rsp_mesh_done;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   logic [CFG_W-1:0]     lat_setting = LAT_RESET;
   logic [CFG_W-1:0]     lon_setting = LONG_RESET;
   logic [1:0]           walk_phase = PH_BAND;
   int unsigned          walk_row = 0;
   int unsigned          walk_col = 0;
   bit                   walk_second = 1'b0;
   int unsigned          walk_base = 0;

   triangle_type         pending_triangles[$];
   stim_row_type         stim_rows[$];
   triangle_type         head_tri;
   int                   failures = 0;
   bit                   hold_wanted = 1'b0;

   uv_sphere_index_generator_top #(
      .MAX_DIVISIONS(MAX_DIVISIONS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_vertex_a(rsp_vertex_a),
      .rsp_vertex_b(rsp_vertex_b),
      .rsp_vertex_c(rsp_vertex_c),
      .rsp_mesh_done(rsp_mesh_done),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_walk();
      walk_phase = PH_BAND;
      walk_row = 0;
      walk_col = 0;
      walk_second = 1'b0;
      walk_base = 0;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
      if (idx == CSR_LAT_DIVISIONS) begin
         lat_setting = data;
         clear_walk();
      end else if (idx == CSR_LONG_DIVISIONS) begin
         lon_setting = data;
         clear_walk();
      end
   endfunction

   function automatic triangle_type next_triangle(input logic restart);
      int unsigned lat, lon, north, south, last_row, r, nb, col, a, b, c;
      triangle_type t;
      lat = 32'(lat_setting);
      if (lat < LAT_MIN) lat = 32'(LAT_MIN);
      if (lat > MAX_DIVISIONS) lat = MAX_DIVISIONS;
      lon = 32'(lon_setting);
      if (lon < LONG_MIN) lon = 32'(LONG_MIN);
      if (lon > MAX_DIVISIONS) lon = MAX_DIVISIONS;
      north = (lat - 1) * lon;
      south = north + 1;
      last_row = north - lon;
      t = '0;
      if (restart) clear_walk();
      if ((walk_phase == PH_BAND || walk_phase == PH_BAND_WRAP) && lat == 2)
         walk_phase = PH_CAP;
      r = walk_base;
      nb = walk_base + lon;
      col = walk_col;
      case (walk_phase)
         PH_BAND: begin
            if (!walk_second) begin
               a = nb + col + 1; b = nb + col; c = r + col + 1;
               walk_second = 1'b1;
            end else begin
               a = r + col + 1; b = nb + col; c = r + col;
               walk_second = 1'b0;
               walk_col = col + 1;
               if (walk_col >= lon - 1) begin
                  walk_col = 0;
                  walk_phase = PH_BAND_WRAP;
               end
            end
         end
         PH_BAND_WRAP: begin
            if (!walk_second) begin
               a = nb; b = nb + lon - 1; c = r;
               walk_second = 1'b1;
            end else begin
               a = r; b = nb + lon - 1; c = r + lon - 1;
               walk_second = 1'b0;
               walk_row = walk_row + 1;
               walk_base = walk_base + lon;
               walk_phase = (walk_row >= lat - 2) ? PH_CAP : PH_BAND;
            end
         end
         PH_CAP: begin
            if (!walk_second) begin
               a = col + 1; b = col; c = north;
               walk_second = 1'b1;
            end else begin
               a = south; b = last_row + col; c = last_row + col + 1;
               walk_second = 1'b0;
               walk_col = col + 1;
               if (walk_col >= lon - 1) begin
                  walk_col = 0;
                  walk_phase = PH_POLE_WRAP;
               end
            end
         end
         default: begin
            if (!walk_second) begin
               a = 0; b = lon - 1; c = north;
               walk_second = 1'b1;
            end else begin
               a = south; b = last_row + lon - 1; c = last_row;
               t.mesh_done = 1'b1;
               clear_walk();
            end
         end
      endcase
      t.vertex_a = VTX_W'(a);
      t.vertex_b = VTX_W'(b);
      t.vertex_c = VTX_W'(c);
      return t;
   endfunction

   function automatic void add_step(input logic restart);
      stim_row_type row;
      row = '{kind: ROW_STEP, restart: restart, idx: '0, data: '0, typed: 1'b0,
              tri_want: '0};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic restart, input int a, input int b,
                                     input int c, input logic done);
      stim_row_type row;
      row = '{kind: ROW_STEP, restart: restart, idx: '0, data: '0, typed: 1'b1,
              tri_want: '0};
      row.tri_want.vertex_a = VTX_W'(a);
      row.tri_want.vertex_b = VTX_W'(b);
      row.tri_want.vertex_c = VTX_W'(c);
      row.tri_want.mesh_done = done;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
      stim_row_type row;
      row = '{kind: ROW_WRITE, restart: 1'b0, idx: idx, data: data, typed: 1'b0,
              tri_want: '0};
      stim_rows.push_back(row);
   endfunction

   // Every task below starts and ends just after a rising edge.
   task automatic offer_step(input logic restart, input bit typed, input triangle_type want);
      triangle_type calc;
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      calc = next_triangle(restart);
      pending_triangles.push_back(typed ? want : calc);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_triangles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      apply_reg_write(idx, data);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_triangles.size() == 0) begin
            $error("rsp word arrived with no triangle expected");
            failures++;
         end else begin
            head_tri = pending_triangles.pop_front();
            if (rsp_vertex_a !== head_tri.vertex_a) begin
               $error("vertex_a expected %0d got %0d", head_tri.vertex_a, rsp_vertex_a);
               failures++;
            end
            if (rsp_vertex_b !== head_tri.vertex_b) begin
               $error("vertex_b expected %0d got %0d", head_tri.vertex_b, rsp_vertex_b);
               failures++;
            end
            if (rsp_vertex_c !== head_tri.vertex_c) begin
               $error("vertex_c expected %0d got %0d", head_tri.vertex_c, rsp_vertex_c);
               failures++;
            end
            if (rsp_mesh_done !== head_tri.mesh_done) begin
               $error("mesh_done expected %0d got %0d", head_tri.mesh_done, rsp_mesh_done);
               failures++;
            end
         end
      end
   end

   initial begin : result_sink
      int span;
      int mode;
      span = 0;
      mode = 0;
      forever begin
         if (hold_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_wanted = 1'b0;
         end else begin
            if (span == 0) begin
               span = $urandom_range(1, 60);
               mode = $urandom_range(0, 3);
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            span--;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("uv_sphere_index_generator_top: mismatch");
      $finish;
   end

   initial begin : stimulus
      int n;
      int burst;
      int random_items;
      int restart_odds;
      int pick;
      bit first_phase;
      logic [CFG_W-1:0] lat_pick;
      logic [CFG_W-1:0] lon_pick;

      add_typed(1'b0, 25, 24, 1, 1'b0);
      add_typed(1'b0, 1, 24, 0, 1'b0);
      add_typed(1'b1, 25, 24, 1, 1'b0);
      add_step(1'b0);
      add_step(1'b0);
      // Two latitude divisions: no bands, the walk is caps then pole wraps.
      add_write(CSR_LAT_DIVISIONS, LAT_MIN);
      add_write(CSR_LONG_DIVISIONS, LONG_MIN);
      add_typed(1'b0, 1, 0, 3, 1'b0);
      add_typed(1'b0, 4, 0, 1, 1'b0);
      add_typed(1'b0, 2, 1, 3, 1'b0);
      add_typed(1'b0, 4, 1, 2, 1'b0);
      add_typed(1'b0, 0, 2, 3, 1'b0);
      add_typed(1'b0, 4, 2, 0, 1'b1);
      add_typed(1'b0, 1, 0, 3, 1'b0);
      // Settings below the minimum saturate.
      add_write(CSR_LAT_DIVISIONS, 9'd0);
      add_write(CSR_LONG_DIVISIONS, 9'd1);
      add_typed(1'b0, 1, 0, 3, 1'b0);
      add_typed(1'b1, 1, 0, 3, 1'b0);
      // Settings above the maximum saturate; writes to spare indexes leave the walk alone.
      add_write(CSR_LAT_DIVISIONS, 9'd511);
      add_write(CSR_LONG_DIVISIONS, 9'd511);
      add_typed(1'b0, 257, 256, 1, 1'b0);
      add_write(CSR_SPARE_LO, 9'd511);
      add_typed(1'b0, 1, 256, 0, 1'b0);
      add_write(CSR_SPARE_HI, 9'd0);
      add_typed(1'b0, 258, 257, 2, 1'b0);
      add_write(CSR_LAT_DIVISIONS, 9'd256);
      add_write(CSR_LONG_DIVISIONS, 9'd256);
      add_typed(1'b1, 257, 256, 1, 1'b0);
      add_write(CSR_LAT_DIVISIONS, 9'd3);
      add_step(1'b0);
      add_step(1'b0);
      add_step(1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE) begin
            drain_results();
            write_reg(stim_rows[i].idx, stim_rows[i].data);
         end else begin
            offer_step(stim_rows[i].restart, stim_rows[i].typed, stim_rows[i].tri_want);
         end
      end

      random_items = 0;
      first_phase = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         pick = first_phase ? 0 : $urandom_range(0, 9);
         if (pick <= 6) begin
            lat_pick = CFG_W'($urandom_range(2, 7));
            lon_pick = CFG_W'($urandom_range(3, 9));
         end else if (pick == 7) begin
            lat_pick = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 1))
                                                   : CFG_W'($urandom_range(257, 511));
            lon_pick = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 2))
                                                   : CFG_W'($urandom_range(257, 511));
         end else if (pick == 8) begin
            lat_pick = CFG_W'($urandom_range(0, 511));
            lon_pick = CFG_W'($urandom_range(0, 511));
         end else begin
            lat_pick = ($urandom_range(0, 1) == 0) ? 9'd2 : 9'd256;
            lon_pick = ($urandom_range(0, 1) == 0) ? 9'd3 : 9'd256;
         end
         drain_results();
         write_reg(CSR_LAT_DIVISIONS, lat_pick);
         write_reg(CSR_LONG_DIVISIONS, lon_pick);
         if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CFG_W'($urandom_range(0, 511)));
         if (first_phase) begin
            hold_wanted = 1'b1;
            n = 250;
         end else begin
            n = (pick <= 6) ? $urandom_range(40, 200) : $urandom_range(20, 80);
         end
         first_phase = 1'b0;
         restart_odds = ($urandom_range(0, 3) == 0) ? 8 : 100;
         burst = 0;
         repeat (n) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 40);
               if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
            end
            offer_step($urandom_range(1, restart_odds) == 1, 1'b0, '0);
            burst--;
            random_items++;
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("uv_sphere_index_generator_top: match");
      end else begin
         $display("uv_sphere_index_generator_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/usig_pkg.sv
design/usig_cfg.sv
design/usig_walk.sv
design/uv_sphere_index_generator_top.sv
tb/sv/tb_uv_sphere_index_generator_top.sv
